// File: rtl/suar_pkg.sv
`default_nettype none

package suar_pkg;

   // Field widths of the request and response
   localparam int DataW     = 32;
   localparam int CommandW  = 2;
   localparam int PositionW = 5;
   localparam int CountW    = 5;

   // Default number of entries
   localparam int CapacityDefault = 16;

   typedef enum logic [CommandW-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_REPLACE = 2'd2,
      CMD_SEARCH  = 2'd3
   } cmd_type;

   // Broadcast from the sequencer to every cell
   typedef struct packed {
      logic                    ins;
      logic                    rem;
      logic signed [DataW-1:0] key;
   } cell_ctrl_type;

   // What a cell shows its neighbors
   typedef struct packed {
      logic signed [DataW-1:0] entry;
      logic                    valid;
      logic                    gt;
   } cell_link_type;

endpackage

`default_nettype wire

// File: rtl/suar_cell.sv
`default_nettype none

module suar_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  suar_pkg::cell_ctrl_type  ctrl,
   input  suar_pkg::cell_link_type  left_link,
   input  suar_pkg::cell_link_type  right_link,
   output suar_pkg::cell_link_type  self_link,
   output logic                     eq
);
   import suar_pkg::*;

   logic signed [DataW-1:0] entry_ff, entry_in;
   logic                    valid_ff, valid_in;
   logic                    gt;
   logic                    ge;
   logic                    take_left;
   logic                    take_right;

   // Compare the held entry against the broadcast key
   assign gt = valid_ff && (entry_ff > ctrl.key);
   assign eq = valid_ff && (entry_ff == ctrl.key);
   assign ge = gt || eq;

   // Insert: open a slot above the key, or fill the first free slot
   assign take_left  = ctrl.ins && (gt || (!valid_ff && left_link.valid));
   // Remove: every entry from the match upward pulls in its right neighbor
   assign take_right = ctrl.rem && ge;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (take_left) begin
         entry_in = left_link.gt ? left_link.entry : ctrl.key;
         valid_in = 1'b1;
      end else if (take_right) begin
         entry_in = right_link.entry;
         valid_in = right_link.valid;
      end
   end

   // Hold the occupied flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the value
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign self_link = '{entry: entry_ff, valid: valid_ff, gt: gt};

endmodule

`default_nettype wire

// File: rtl/sorted_unique_set_array.sv
`default_nettype none

// Sorted set of distinct signed 32-bit values, kept ascending in a row of
// compare-and-shift cells, one value per cell. Commands: insert (refused when
// full or already present), remove (refused when absent), replace (remove old
// value, then insert the new one; status reports the removal only) and search
// (returns the index or -1). Every request yields one response carrying the
// occupied count after the request. A request is registered first and is then
// executed by the whole row: insert, remove and search in one pass, replace in
// a remove pass and then, if the old value was found, an insert pass. The
// response register frees the row for the next request while a response waits;
// the row waits only if the response is still stalled.
module sorted_unique_set_array #(
   parameter int Capacity = suar_pkg::CapacityDefault
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  suar_pkg::cmd_type                    req_command,
   input  wire signed [suar_pkg::DataW-1:0]     req_value,
   input  wire signed [suar_pkg::DataW-1:0]     req_old_value,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_status,
   output logic signed [suar_pkg::PositionW-1:0] rsp_position,
   output logic [suar_pkg::CountW-1:0]          rsp_count
);
   import suar_pkg::*;

   localparam int IdxW = $clog2(Capacity);
   localparam int CntW = $clog2(Capacity + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_PASS2
   } state_type;

   state_type               state_ff;
   cmd_type                 cmd_ff;
   logic signed [DataW-1:0] value_ff;
   logic signed [DataW-1:0] old_ff;
   logic [CntW-1:0]         count_ff, count_in;

   logic                    rsp_valid_ff;
   logic                    rsp_status_ff, rsp_status_in;
   logic [PositionW-1:0]    rsp_position_ff, rsp_position_in;
   logic [CountW-1:0]       rsp_count_ff;

   cell_ctrl_type           ctrl;
   cell_link_type           links [Capacity];
   logic [Capacity-1:0]     eq_vec;
   logic [Capacity-1:0]     valid_vec;
   logic                    found;
   logic [IdxW-1:0]         hit_idx;
   logic                    full;
   logic                    out_free;
   logic                    fire;
   logic                    finish;
   logic [IdxW+PositionW-1:0] pos_wide;
   logic [CntW+CountW-1:0]  cnt_wide;

   // Build the row of cells
   for (genvar i = 0; i < Capacity; i++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;
      if (i == 0) begin : g_first
         assign left_link = '{entry: '0, valid: 1'b1, gt: 1'b0};
      end else begin : g_mid
         assign left_link = links[i-1];
      end
      if (i == Capacity - 1) begin : g_last
         assign right_link = '{entry: '0, valid: 1'b0, gt: 1'b0};
      end else begin : g_inner
         assign right_link = links[i+1];
      end
      suar_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_link  (left_link),
         .right_link (right_link),
         .self_link  (links[i]),
         .eq         (eq_vec[i])
      );
      assign valid_vec[i] = links[i].valid;
   end

   // Combine the match flags into presence and index
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < Capacity; i++) begin
         hit_idx = hit_idx | (eq_vec[i] ? IdxW'(i) : '0);
      end
   end
   assign found = |eq_vec;
   assign full  = (count_ff == CntW'(Capacity));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = (state_ff != S_IDLE) && out_free;

   // Drive the row and build the response
   always_comb begin
      ctrl.key        = value_ff;
      ctrl.ins        = 1'b0;
      ctrl.rem        = 1'b0;
      rsp_status_in   = 1'b1;
      pos_wide        = '1;
      finish          = 1'b0;
      count_in        = count_ff;
      if (state_ff == S_RUN && cmd_ff == CMD_REPLACE) begin
         ctrl.key = old_ff;
      end
      if (fire) begin
         unique case (state_ff)
            S_PASS2: begin
               ctrl.ins      = !found && !full;
               rsp_status_in = 1'b0;
               finish        = 1'b1;
            end
            default: begin
               unique case (cmd_ff)
                  CMD_INSERT: begin
                     ctrl.ins      = !found && !full;
                     rsp_status_in = found || full;
                     finish        = 1'b1;
                  end
                  CMD_REMOVE: begin
                     ctrl.rem      = found;
                     rsp_status_in = !found;
                     finish        = 1'b1;
                  end
                  CMD_REPLACE: begin
                     ctrl.rem      = found;
                     rsp_status_in = 1'b1;
                     finish        = !found;
                  end
                  default: begin
                     rsp_status_in = !found;
                     if (found) begin
                        pos_wide = {{PositionW{1'b0}}, hit_idx};
                     end
                     finish = 1'b1;
                  end
               endcase
            end
         endcase
      end
      if (ctrl.ins) begin
         count_in = count_ff + CntW'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CntW'(1);
      end
      rsp_position_in = pos_wide[PositionW-1:0];
   end

   assign cnt_wide = {{CountW{1'b0}}, count_in};

   // Sequencer, count and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         // Load a finished response, hold a stalled one, drop a taken one
         rsp_valid_ff <= finish || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               if (fire) begin
                  state_ff <= finish ? S_IDLE : S_PASS2;
               end
            end
            S_PASS2: begin
               if (fire) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Capture the request and the response payload
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
         old_ff   <= req_old_value;
      end
      if (finish) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_position_ff <= rsp_position_in;
         rsp_count_ff    <= cnt_wide[CountW-1:0];
      end
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

   // Occupied cells always match the count
   a_count_matches : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("occupied cells differ from count");

   // Distinct values: at most one cell matches a key
   a_unique_match : assert property (@(posedge clock) disable iff (reset)
      $onehot0(eq_vec))
      else $error("more than one cell matches the key");

   // The insert pass of a replace always finds the response register empty
   a_pass2_free : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PASS2 |-> !rsp_valid_ff)
      else $error("response pending during second pass");

endmodule

`default_nettype wire
